@@ hw/rtl/epq_pkg.sv @@
// Shared types and constants for the expiring minimum priority queue.
// Used by epq_cmp and expiring_min_priority_queue; no dependencies.
package epq_pkg;

  localparam int unsigned DEPTH_DEF = 1024;

  localparam int unsigned PRICE_W = 30;
  localparam int unsigned DUR_W   = 20;
  localparam int unsigned EXP_W   = 32;

  localparam logic [PRICE_W-1:0] MAX_PRICE = 30'd1000000000;
  localparam logic [PRICE_W-1:0] NO_OFFER  = 30'd1000000001;

  typedef struct packed {
    logic [PRICE_W-1:0] offer_price;
    logic [DUR_W-1:0]   offer_duration;
  } in_t;

  typedef struct packed {
    logic [PRICE_W-1:0] min_active_price;
    logic               overflow;
  } out_t;

  // One stored heap entry.
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [EXP_W-1:0]   expiry;
  } entry_t;

  // Request to the shared price comparator: pick the lowest of base and
  // the enabled candidates, moving off base only on a strictly lower price.
  typedef struct packed {
    entry_t base;
    entry_t cand_a;
    logic   cand_a_en;
    entry_t cand_b;
    logic   cand_b_en;
  } cmp_req_t;

  typedef struct packed {
    logic pick_a;
    logic pick_b;
  } cmp_res_t;

endpackage

@@ hw/rtl/epq_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module epq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ hw/rtl/epq_cmp.sv @@
// Shared price comparator for the heap sequencer: selects the lowest price
// of a base entry and up to two candidates. Depends on epq_pkg.
module epq_cmp (
  input  epq_pkg::cmp_req_t req,
  output epq_pkg::cmp_res_t res
);

  logic                        a_lt;
  logic [epq_pkg::PRICE_W-1:0] low_price;
  logic                        b_lt;

  // Left candidate wins a tie against the right one.
  always_comb begin
    a_lt      = req.cand_a_en && (req.cand_a.price < req.base.price);
    low_price = a_lt ? req.cand_a.price : req.base.price;
    b_lt      = req.cand_b_en && (req.cand_b.price < low_price);
    res.pick_b = b_lt;
    res.pick_a = a_lt && !b_lt;
  end

endmodule

@@ hw/rtl/expiring_min_priority_queue.sv @@
// From accept, the sequencer checks the request against the root; a request that is not dropped
// and finds room climbs from a hole at the tail toward the root; then each expired root is
// popped and the tail entry sunk from the root, until the root is live or the queue is empty.
// Throughput: one request at a time; busy stays high until the result strobe.
// The result strobe lasts one cycle and cannot be stalled; a new start is taken with it.
// Synchronous active-low reset clears the count, day counter and sequencer; RAM is not cleared.
module expiring_min_priority_queue #(
  parameter int unsigned DEPTH = epq_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  epq_pkg::in_t  in_data,
  output logic          out_valid,
  output epq_pkg::out_t out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned EW = $bits(epq_pkg::entry_t);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_CHECK   = 9'b000000010,
    ST_UP_RD   = 9'b000000100,
    ST_UP_CMP  = 9'b000001000,
    ST_POP_RD  = 9'b000010000,
    ST_POP_CHK = 9'b000100000,
    ST_POP_LD  = 9'b001000000,
    ST_DN_RD   = 9'b010000000,
    ST_DN_CMP  = 9'b100000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [epq_pkg::EXP_W-1:0]  day_r, day_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  epq_pkg::entry_t            item_r, item_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       out_valid_r, out_valid_nxt;
  epq_pkg::out_t              out_data_r, out_data_nxt;

  // RAM port signals
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  epq_pkg::entry_t            wr_entry;
  logic [AW-1:0]              rd_addr_a, rd_addr_b;
  logic [EW-1:0]              rd_raw_a, rd_raw_b;
  epq_pkg::entry_t            rd_a, rd_b;

  epq_pkg::cmp_req_t          cmp_req;
  epq_pkg::cmp_res_t          cmp_res;

  // Heap index arithmetic
  logic [CW:0]                left_w, right_w, count_ext;
  logic [AW-1:0]              pos_m1, parent_w, last_w;
  logic [epq_pkg::EXP_W:0]    exp_sum;
  logic [epq_pkg::EXP_W-1:0]  day_inc;
  logic [epq_pkg::PRICE_W-1:0] price_sat;
  logic                       dominated, expired, full;

  assign rd_a = epq_pkg::entry_t'(rd_raw_a);
  assign rd_b = epq_pkg::entry_t'(rd_raw_b);

  assign left_w    = {1'b0, pos_r, 1'b1};
  assign right_w   = left_w + (CW+1)'(1);
  assign count_ext = {1'b0, count_r};
  assign pos_m1    = pos_r - AW'(1);
  assign parent_w  = pos_m1 >> 1;
  assign last_w    = AW'(count_r - CW'(1));
  assign full      = (count_r == CW'(DEPTH));

  // Day advance and saturating expiry for the incoming request.
  assign day_inc   = day_r + epq_pkg::EXP_W'(1);
  assign exp_sum   = {1'b0, day_inc} + (epq_pkg::EXP_W+1)'(in_data.offer_duration);
  assign price_sat = (in_data.offer_price > epq_pkg::MAX_PRICE) ?
                     epq_pkg::MAX_PRICE : in_data.offer_price;

  // Comparator routing: sift-down compares the children against the moving
  // entry; everywhere else the moving entry is the candidate against RAM data.
  always_comb begin
    cmp_req.base      = rd_a;
    cmp_req.cand_a    = item_r;
    cmp_req.cand_a_en = 1'b1;
    cmp_req.cand_b    = rd_b;
    cmp_req.cand_b_en = 1'b0;
    if (state_r == ST_DN_CMP) begin
      cmp_req.base      = item_r;
      cmp_req.cand_a    = rd_a;
      cmp_req.cand_b_en = (right_w < count_ext);
    end
  end

  epq_cmp u_cmp (
    .req (cmp_req),
    .res (cmp_res)
  );

  // Drop the request when it expires no later than the root and is not cheaper.
  assign dominated = (count_r != '0) && !cmp_res.pick_a && (item_r.expiry <= rd_a.expiry);
  assign expired   = (count_r != '0) && (rd_a.expiry < day_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    day_nxt       = day_r;
    pos_nxt       = pos_r;
    item_nxt      = item_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_entry      = item_r;
    rd_addr_a     = '0;
    rd_addr_b     = '0;

    case (state_r)
      ST_IDLE: begin
        // Read the root while latching the request.
        if (start) begin
          day_nxt         = day_inc;
          item_nxt.price  = price_sat;
          item_nxt.expiry = exp_sum[epq_pkg::EXP_W] ? '1 : exp_sum[epq_pkg::EXP_W-1:0];
          ovf_nxt         = 1'b0;
          state_nxt       = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (dominated) begin
          state_nxt = ST_POP_RD;
        end else if (full) begin
          ovf_nxt   = 1'b1;
          state_nxt = ST_POP_RD;
        end else begin
          // Open a hole at the tail and climb from there.
          pos_nxt   = count_r[AW-1:0];
          count_nxt = count_r + CW'(1);
          state_nxt = ST_UP_RD;
        end
      end

      ST_UP_RD: begin
        rd_addr_a = parent_w;
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = ST_POP_RD;
        end else begin
          state_nxt = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        wr_en = 1'b1;
        if (cmp_res.pick_a) begin
          // Parent is strictly dearer: pull it down into the hole.
          wr_entry  = rd_a;
          pos_nxt   = parent_w;
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = ST_POP_RD;
        end
      end

      ST_POP_RD: begin
        state_nxt = ST_POP_CHK;
      end

      ST_POP_CHK: begin
        rd_addr_a = last_w;
        if (expired) begin
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            out_valid_nxt                 = 1'b1;
            out_data_nxt.min_active_price = epq_pkg::NO_OFFER;
            out_data_nxt.overflow         = ovf_r;
            state_nxt                     = ST_IDLE;
          end else begin
            state_nxt = ST_POP_LD;
          end
        end else begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.min_active_price = (count_r != '0) ? rd_a.price : epq_pkg::NO_OFFER;
          out_data_nxt.overflow         = ovf_r;
          state_nxt                     = ST_IDLE;
        end
      end

      ST_POP_LD: begin
        // Move the tail entry into the root hole and sink it.
        item_nxt  = rd_a;
        pos_nxt   = '0;
        state_nxt = ST_DN_RD;
      end

      ST_DN_RD: begin
        rd_addr_a = left_w[AW-1:0];
        rd_addr_b = right_w[AW-1:0];
        if (left_w < count_ext) begin
          state_nxt = ST_DN_CMP;
        end else begin
          wr_en     = 1'b1;
          state_nxt = ST_POP_RD;
        end
      end

      ST_DN_CMP: begin
        wr_en = 1'b1;
        if (cmp_res.pick_b) begin
          wr_entry  = rd_b;
          pos_nxt   = right_w[AW-1:0];
          state_nxt = ST_DN_RD;
        end else if (cmp_res.pick_a) begin
          wr_entry  = rd_a;
          pos_nxt   = left_w[AW-1:0];
          state_nxt = ST_DN_RD;
        end else begin
          state_nxt = ST_POP_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      day_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      day_r       <= day_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    item_r     <= item_nxt;
    ovf_r      <= ovf_nxt;
    out_data_r <= out_data_nxt;
  end

  epq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_heap_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (EW'(wr_entry)),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_raw_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_raw_b)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Hold the fill level within the store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // Emit a result only on the way back to idle.
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe outside idle");

  // Advance to the root check right after an accepted request.
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_CHECK))
    else $error("accepted request did not reach root check");

  // Each result closes a request that was in flight.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_POP_CHK))
    else $error("result without a pop check");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

endmodule
